// File: design/feedback_queue_scheduler_defines.svh
// Assertion macros shared by the scheduler's checking code
`ifndef FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define FQS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Check that a condition implies another in the next cycle
`define FQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// File: design/fqs_pkg.sv
// Shared constants, job record and control types of the feedback queue scheduler
`timescale 1ns / 1ps
package fqs_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int PEND_DEPTH  = 16;
	localparam int KINDS       = 4;
	localparam int NLEVELS     = 4;
	localparam int QA_W        = $clog2(QUEUE_DEPTH);
	localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int PA_W        = $clog2(PEND_DEPTH);
	localparam int PC_W        = $clog2(PEND_DEPTH + 1);

	localparam logic [2:0] LVL_NONE = 3'd4;

	// Result event codes
	localparam logic [2:0] EV_ACCEPT  = 3'd0;
	localparam logic [2:0] EV_REJECT  = 3'd1;
	localparam logic [2:0] EV_IDLE    = 3'd2;
	localparam logic [2:0] EV_RAN     = 3'd3;
	localparam logic [2:0] EV_FINISH  = 3'd4;
	localparam logic [2:0] EV_KILL    = 3'd5;
	localparam logic [2:0] EV_PREEMPT = 3'd6;
	localparam logic [2:0] EV_MOVED   = 3'd7;

	// Configuration register indexes
	localparam logic [2:0] CFG_PRINTERS = 3'd0;
	localparam logic [2:0] CFG_SCANNERS = 3'd1;
	localparam logic [2:0] CFG_MODEMS   = 3'd2;
	localparam logic [2:0] CFG_DRIVES   = 3'd3;
	localparam logic [2:0] CFG_KILL     = 3'd4;
	localparam logic [2:0] CFG_QHIGH    = 3'd5;
	localparam logic [2:0] CFG_QMID     = 3'd6;
	localparam logic [2:0] CFG_QLOW     = 3'd7;

	localparam logic [KINDS-1:0][3:0] FREE_RESET = {4'd2, 4'd1, 4'd1, 4'd2};
	localparam logic [7:0] KILL_RESET  = 8'd20;
	localparam logic [3:0] QHIGH_RESET = 4'd3;
	localparam logic [3:0] QMID_RESET  = 4'd2;
	localparam logic [3:0] QLOW_RESET  = 4'd1;

	typedef struct packed {
		logic [KINDS-1:0][3:0] need;
		logic [3:0]            quantum;
		logic [7:0]            rem;
		logic [7:0]            tag;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef struct packed {
		logic capture;
		logic arrive;
		logic adm_start;
		logic adm_next;
		logic adm_take;
		logic chg_sel;
		logic chg_exec;
		logic nxt_sel;
		logic nxt_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic pend_empty;
		logic adm_last;
		logic fits;
		logic none_sel;
		logic out_busy;
	} sts_t;
endpackage

// File: design/fqs_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module fqs_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: design/fqs_ctrl.sv
// Sequencer that steps the datapath through arrival and tick processing
`timescale 1ns / 1ps
module fqs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	output logic          idle,
	input  fqs_pkg::sts_t sts,
	output fqs_pkg::cmd_t cmd
);
	import fqs_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DEC     = 4'd1;
	localparam logic [3:0] S_ADM_RD  = 4'd2;
	localparam logic [3:0] S_ADM_CHK = 4'd3;
	localparam logic [3:0] S_CHG_SEL = 4'd4;
	localparam logic [3:0] S_CHG_EXE = 4'd5;
	localparam logic [3:0] S_NXT_SEL = 4'd6;
	localparam logic [3:0] S_NXT_LD  = 4'd7;
	localparam logic [3:0] S_OUT     = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_n;

	assign idle = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.capture = 1'b1;
					state_n     = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.is_tick) begin
					cmd.adm_start = 1'b1;
					state_n       = S_ADM_RD;
				end else begin
					cmd.arrive = 1'b1;
					state_n    = S_OUT;
				end
			end
			S_ADM_RD: begin
				if (!sts.pend_empty) begin
					state_n = S_ADM_CHK;
				end else if (sts.adm_last) begin
					state_n = S_CHG_SEL;
				end else begin
					cmd.adm_next = 1'b1;
				end
			end
			S_ADM_CHK: begin
				if (sts.fits) begin
					cmd.adm_take = 1'b1;
					state_n      = S_ADM_RD;
				end else begin
					state_n = S_CHG_SEL;
				end
			end
			S_CHG_SEL: begin
				cmd.chg_sel = 1'b1;
				state_n     = sts.none_sel ? S_NXT_SEL : S_CHG_EXE;
			end
			S_CHG_EXE: begin
				cmd.chg_exec = 1'b1;
				state_n      = S_NXT_SEL;
			end
			S_NXT_SEL: begin
				cmd.nxt_sel = 1'b1;
				state_n     = S_NXT_LD;
			end
			S_NXT_LD: begin
				cmd.nxt_load = 1'b1;
				state_n      = S_OUT;
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end
endmodule

// File: design/fqs_dp.sv
// Datapath: level queues, pending lists, resources, kill timer and result register
`timescale 1ns / 1ps
module fqs_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  fqs_pkg::cmd_t cmd,
	output fqs_pkg::sts_t sts,
	input  logic [39:0]   s_tdata,
	input  logic          s_tuser,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [7:0]    cfg_data,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [31:0]   m_tdata,
	output logic [2:0]    m_tuser
);
	import fqs_pkg::*;

	// Captured input item
	logic        mode_q;
	logic [1:0]  pri_q;
	job_t        arr_job_q;

	// Level queues and pending lists
	logic [QC_W-1:0] qcnt_q  [NLEVELS];
	logic [QA_W-1:0] qhead_q [NLEVELS];
	logic [QA_W-1:0] qtail   [NLEVELS];
	job_t            qrd     [NLEVELS];
	job_t            qwdat   [NLEVELS];
	logic [NLEVELS-1:0] qpush, qpop, qwb;

	logic [PC_W-1:0] pcnt_q  [1:3];
	logic [PA_W-1:0] phead_q [1:3];
	job_t            prd     [1:3];
	logic [3:1]      ppush, ppop;
	logic [PC_W-1:0] ptotal;

	// Resources, timer and configuration
	logic [KINDS-1:0][3:0] free_q;
	logic [7:0] timer_q, kperiod_q;
	logic [3:0] qhi_q, qmid_q, qlo_q;
	logic [4:0] rel_sum [KINDS];

	// Sequencing registers
	logic [1:0] adm_p_q;
	logic [2:0] lvl_q, run_q;
	logic       expired_q;
	logic [4:0] admitted_q;

	// Result fields
	logic [2:0] ev_q;
	logic [7:0] tag_q, rem_q;
	logic       nv_q;
	logic [7:0] ntag_q;

	logic [2:0] sel_lvl, chg_lvl;
	logic       run_ok, fits, arr_ok;
	logic [7:0] timer_dec;
	job_t       pj, cj;
	logic [1:0] l2, to_lvl;
	logic [7:0] rem_n;
	logic [3:0] qn_n;
	logic       higher, done_c;
	logic [2:0] ev_c;

	function automatic logic [3:0] q_of(input logic [1:0] l, input logic [3:0] hi,
		input logic [3:0] mid, input logic [3:0] lo);
		logic [3:0] r;
		r = lo;
		if (l == 2'd1) r = hi;
		else if (l == 2'd2) r = mid;
		return r;
	endfunction

	// Queue memories, always reading the head entry
	for (genvar l = 0; l < NLEVELS; l++) begin : g_q
		assign qtail[l] = qhead_q[l] + qcnt_q[l][QA_W-1:0];
		fqs_ram #(.W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_ram (
			.clk   (clk),
			.we    (qpush[l] | qwb[l]),
			.waddr (qwb[l] ? qhead_q[l] : qtail[l]),
			.wdata (qwdat[l]),
			.raddr (qhead_q[l]),
			.rdata (qrd[l])
		);
	end

	// Pending memories, one per user level
	for (genvar p = 1; p <= 3; p++) begin : g_p
		fqs_ram #(.W(JOB_W), .DEPTH(PEND_DEPTH)) u_ram (
			.clk   (clk),
			.we    (ppush[p]),
			.waddr (phead_q[p] + pcnt_q[p][PA_W-1:0]),
			.wdata (arr_job_q),
			.raddr (phead_q[p]),
			.rdata (prd[p])
		);
	end

	assign ptotal = pcnt_q[1] + pcnt_q[2] + pcnt_q[3];

	// Highest non-empty level
	always_comb begin
		sel_lvl = LVL_NONE;
		for (int l = NLEVELS - 1; l >= 0; l--) begin
			if (qcnt_q[l] != '0) sel_lvl = 3'(l);
		end
	end

	assign run_ok  = (run_q != LVL_NONE) && (qcnt_q[run_q[1:0]] != '0);
	assign chg_lvl = run_ok ? run_q : sel_lvl;
	assign timer_dec = timer_q - 8'd1;

	// Admission check on the pending head
	always_comb begin
		pj   = prd[adm_p_q];
		fits = (qcnt_q[adm_p_q] < QC_W'(QUEUE_DEPTH));
		for (int k = 0; k < KINDS; k++) begin
			if (pj.need[k] > free_q[k]) fits = 1'b0;
		end
	end

	// Charge decision for the running head
	always_comb begin
		l2     = lvl_q[1:0];
		cj     = qrd[l2];
		rem_n  = (cj.rem != 8'd0) ? cj.rem - 8'd1 : 8'd0;
		qn_n   = (l2 != 2'd0 && cj.quantum != 4'd0) ? cj.quantum - 4'd1 : cj.quantum;
		higher = 1'b0;
		for (int k = 0; k < NLEVELS - 1; k++) begin
			if (k < int'(l2) && qcnt_q[k] != '0) higher = 1'b1;
		end
		to_lvl = (l2 == 2'd3) ? 2'd3 : l2 + 2'd1;
		done_c = (rem_n == 8'd0) || expired_q;
		if (rem_n == 8'd0) ev_c = EV_FINISH;
		else if (expired_q) ev_c = EV_KILL;
		else if (l2 != 2'd0 && higher) ev_c = EV_PREEMPT;
		else if (l2 != 2'd0 && qn_n == 4'd0) ev_c = EV_MOVED;
		else ev_c = EV_RAN;
		for (int k = 0; k < KINDS; k++) begin
			rel_sum[k] = {1'b0, free_q[k]} + {1'b0, cj.need[k]};
		end
	end

	assign arr_ok = (pri_q == 2'd0) ? (qcnt_q[0] < QC_W'(QUEUE_DEPTH))
		: (ptotal < PC_W'(PEND_DEPTH));

	// Queue write, push and pop requests
	always_comb begin
		qpush = '0;
		qpop  = '0;
		qwb   = '0;
		ppush = '0;
		ppop  = '0;
		for (int l = 0; l < NLEVELS; l++) qwdat[l] = cj;
		if (cmd.arrive && arr_ok) begin
			if (pri_q == 2'd0) begin
				qpush[0] = 1'b1;
				qwdat[0] = arr_job_q;
			end else begin
				ppush[pri_q] = 1'b1;
			end
		end
		if (cmd.adm_take) begin
			ppop[adm_p_q]  = 1'b1;
			qpush[adm_p_q] = 1'b1;
			qwdat[adm_p_q] = pj;
			qwdat[adm_p_q].quantum = q_of(adm_p_q, qhi_q, qmid_q, qlo_q);
		end
		if (cmd.chg_exec) begin
			if (done_c) begin
				qpop[l2] = 1'b1;
			end else if (ev_c == EV_MOVED) begin
				if (to_lvl == l2 || qcnt_q[to_lvl] < QC_W'(QUEUE_DEPTH)) begin
					qpop[l2]      = 1'b1;
					qpush[to_lvl] = 1'b1;
					qwdat[to_lvl].rem     = rem_n;
					qwdat[to_lvl].quantum = q_of(to_lvl, qhi_q, qmid_q, qlo_q);
				end else begin
					qwb[l2]           = 1'b1;
					qwdat[l2].rem     = rem_n;
					qwdat[l2].quantum = q_of(l2, qhi_q, qmid_q, qlo_q);
				end
			end else begin
				qwb[l2]           = 1'b1;
				qwdat[l2].rem     = rem_n;
				qwdat[l2].quantum = qn_n;
			end
		end
	end

	// Queue and pending bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NLEVELS; l++) begin
				qcnt_q[l]  <= '0;
				qhead_q[l] <= '0;
			end
			for (int p = 1; p <= 3; p++) begin
				pcnt_q[p]  <= '0;
				phead_q[p] <= '0;
			end
		end else begin
			for (int l = 0; l < NLEVELS; l++) begin
				qcnt_q[l] <= qcnt_q[l] + QC_W'(qpush[l]) - QC_W'(qpop[l]);
				if (qpop[l]) qhead_q[l] <= qhead_q[l] + QA_W'(1);
			end
			for (int p = 1; p <= 3; p++) begin
				pcnt_q[p] <= pcnt_q[p] + PC_W'(ppush[p]) - PC_W'(ppop[p]);
				if (ppop[p]) phead_q[p] <= phead_q[p] + PA_W'(1);
			end
		end
	end

	// Resources, timer, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q    <= FREE_RESET;
			timer_q   <= KILL_RESET;
			kperiod_q <= KILL_RESET;
			qhi_q     <= QHIGH_RESET;
			qmid_q    <= QMID_RESET;
			qlo_q     <= QLOW_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PRINTERS, CFG_SCANNERS, CFG_MODEMS, CFG_DRIVES:
						free_q[cfg_idx[1:0]] <= cfg_data[3:0];
					CFG_KILL: begin
						kperiod_q <= cfg_data;
						timer_q   <= cfg_data;
					end
					CFG_QHIGH: qhi_q  <= cfg_data[3:0];
					CFG_QMID:  qmid_q <= cfg_data[3:0];
					CFG_QLOW:  qlo_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.adm_take) begin
				for (int k = 0; k < KINDS; k++) free_q[k] <= free_q[k] - pj.need[k];
			end
			if (cmd.chg_exec && done_c && l2 != 2'd0) begin
				for (int k = 0; k < KINDS; k++) begin
					free_q[k] <= rel_sum[k][4] ? 4'hF : rel_sum[k][3:0];
				end
			end
			if (cmd.chg_sel) begin
				timer_q <= (timer_dec == 8'd0) ? kperiod_q : timer_dec;
			end
		end
	end

	// Sequencing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= LVL_NONE;
			lvl_q      <= LVL_NONE;
			adm_p_q    <= 2'd1;
			expired_q  <= 1'b0;
			admitted_q <= '0;
			nv_q       <= 1'b0;
			ntag_q     <= '0;
		end else begin
			if (cmd.capture) admitted_q <= '0;
			if (cmd.adm_start) adm_p_q <= 2'd1;
			if (cmd.adm_next) adm_p_q <= adm_p_q + 2'd1;
			if (cmd.adm_take) admitted_q <= admitted_q + 5'd1;
			if (cmd.chg_sel) begin
				lvl_q     <= chg_lvl;
				expired_q <= (timer_dec == 8'd0);
			end
			if (cmd.nxt_sel) run_q <= sel_lvl;
			if (cmd.nxt_load) begin
				nv_q   <= (run_q != LVL_NONE);
				ntag_q <= (run_q != LVL_NONE) ? qrd[run_q[1:0]].tag : 8'd0;
			end
		end
	end

	// Capture input item and result fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= s_tuser;
			pri_q     <= s_tdata[9:8];
			arr_job_q <= '{need: s_tdata[33:18], quantum: 4'd0,
				rem: s_tdata[17:10], tag: s_tdata[7:0]};
		end
		if (cmd.arrive) begin
			ev_q  <= arr_ok ? EV_ACCEPT : EV_REJECT;
			tag_q <= arr_job_q.tag;
			rem_q <= arr_job_q.rem;
		end
		if (cmd.chg_sel) begin
			ev_q  <= EV_IDLE;
			tag_q <= 8'd0;
			rem_q <= 8'd0;
		end
		if (cmd.chg_exec) begin
			ev_q  <= ev_c;
			tag_q <= cj.tag;
			rem_q <= rem_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata <= {2'b00, admitted_q, ntag_q, nv_q, rem_q, tag_q};
			m_tuser <= ev_q;
		end
	end

	assign sts.is_tick    = mode_q;
	assign sts.pend_empty = (pcnt_q[adm_p_q] == '0);
	assign sts.adm_last   = (adm_p_q == 2'd3);
	assign sts.fits       = fits;
	assign sts.none_sel   = (chg_lvl == LVL_NONE);
	assign sts.out_busy   = m_tvalid && !m_tready;
endmodule

// File: design/feedback_queue_scheduler.sv
// Multilevel feedback queue scheduler with a real-time queue and three user levels.
// An arrival item goes from capture and decode straight to output. A tick item walks the pending
// heads level by level, admitting each job that fits and stopping at the first misfit, through
// the single read port of each pending memory, then charges, picks the next job and outputs.
// Results wait in an output register; the next item is taken once the sequencer is idle.
`timescale 1ns / 1ps
`include "feedback_queue_scheduler_defines.svh"
module feedback_queue_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tag[7:0], priority_req[9:8], cpu_time[17:10], need_printers[21:18],
	// need_scanners[25:22], need_modems[29:26], need_drives[33:30], zero fill
	input  logic [39:0] s_tdata,
	// mode
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// job_tag[7:0], remaining[15:8], next_valid[16], next_tag[24:17],
	// admitted[29:25], zero fill
	output logic [31:0] m_tdata,
	// event_res
	output logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [7:0]  cfg_data
);
	import fqs_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle;

	assign s_tready = idle;

	fqs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (s_tvalid && s_tready),
		.idle    (idle),
		.sts     (sts),
		.cmd     (cmd)
	);

	fqs_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	`FQS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`FQS_ASSERT_SAME(a_no_overwrite, clk, arst_n, cmd.out_load, !(m_tvalid && !m_tready))
	`FQS_ASSERT_NEXT(a_result_shown, clk, arst_n, cmd.out_load, m_tvalid)
endmodule

// File: dv/feedback_queue_scheduler_checker.sv
// Checker for the feedback queue scheduler: predicts each result item and compares it
`timescale 1ns / 1ps
module feedback_queue_scheduler_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          outstanding
);
	import fqs_pkg::*;

	typedef struct {
		logic [7:0]       tag;
		logic [7:0]       rem;
		logic [1:0]       lvl;
		logic [3:0]       quantum;
		logic [3:0][3:0]  need;
	} sched_job_t;

	typedef struct {
		logic [2:0] ev;
		logic [7:0] tag;
		logic [7:0] rem;
		logic       nv;
		logic [7:0] nt;
		logic [4:0] adm;
	} sched_result_t;

	localparam int PEND_SLOT = 4;

	sched_job_t    level_q [NLEVELS][QUEUE_DEPTH];
	int            q_head [NLEVELS];
	int            q_count [5];
	sched_job_t    pend_q [PEND_DEPTH];
	logic [3:0]    free_now [KINDS];
	logic [7:0]    kill_left, kill_len;
	logic [3:0]    quant_cfg [1:3];
	int            run_lvl;
	sched_result_t results_due [$];

	assign outstanding = results_due.size();

	function automatic bit push_job(int lvl, sched_job_t j);
		if (q_count[lvl] >= QUEUE_DEPTH) return 0;
		level_q[lvl][(q_head[lvl] + q_count[lvl]) % QUEUE_DEPTH] = j;
		q_count[lvl]++;
		return 1;
	endfunction

	function automatic void pop_job(int lvl);
		q_head[lvl] = (q_head[lvl] + 1) % QUEUE_DEPTH;
		q_count[lvl]--;
	endfunction

	function automatic int top_level();
		for (int l = 0; l < NLEVELS; l++)
			if (q_count[l] > 0) return l;
		return NLEVELS;
	endfunction

	// Admit pending jobs in stable level order; stop at the first misfit
	function automatic int admit_jobs();
		sched_job_t sorted [PEND_DEPTH];
		int n, i, adm;
		bit fits;
		n = 0;
		adm = 0;
		for (int p = 1; p <= 3; p++)
			for (int e = 0; e < q_count[PEND_SLOT]; e++)
				if (pend_q[e].lvl == p) begin
					sorted[n] = pend_q[e];
					n++;
				end
		i = 0;
		while (i < n) begin
			fits = q_count[sorted[i].lvl] < QUEUE_DEPTH;
			for (int k = 0; k < KINDS; k++)
				if (sorted[i].need[k] > free_now[k]) fits = 0;
			if (!fits) break;
			for (int k = 0; k < KINDS; k++)
				free_now[k] = free_now[k] - sorted[i].need[k];
			sorted[i].quantum = quant_cfg[sorted[i].lvl];
			void'(push_job(sorted[i].lvl, sorted[i]));
			adm++;
			i++;
		end
		q_count[PEND_SLOT] = n - i;
		for (int p = 0; i < n; i++, p++)
			pend_q[p] = sorted[i];
		return adm;
	endfunction

	// Compute the result of one input item and advance the scheduler state
	function automatic sched_result_t schedule_item(logic md, logic [33:0] d);
		sched_result_t r;
		sched_job_t j;
		int lvl, to, h;
		bit ok, expired, higher;
		r = '{ev: EV_IDLE, tag: 0, rem: 0, nv: 0, nt: 0, adm: 0};
		if (!md) begin
			j.tag = d[7:0];
			j.lvl = d[9:8];
			j.rem = d[17:10];
			j.quantum = 0;
			for (int k = 0; k < KINDS; k++)
				j.need[k] = d[18 + 4*k +: 4];
			if (j.lvl == 0)
				ok = push_job(0, j);
			else if (q_count[PEND_SLOT] < PEND_DEPTH) begin
				pend_q[q_count[PEND_SLOT]] = j;
				q_count[PEND_SLOT]++;
				ok = 1;
			end else
				ok = 0;
			r.ev = ok ? EV_ACCEPT : EV_REJECT;
			r.tag = j.tag;
			r.rem = j.rem;
		end else begin
			r.adm = admit_jobs();
			kill_left = kill_left - 8'd1;
			expired = kill_left == 0;
			if (expired) kill_left = kill_len;
			lvl = run_lvl;
			if (lvl >= NLEVELS || q_count[lvl] == 0) lvl = top_level();
			if (lvl < NLEVELS) begin
				h = q_head[lvl];
				higher = 0;
				for (int k = 0; k < lvl; k++)
					if (q_count[k] > 0) higher = 1;
				if (level_q[lvl][h].rem > 0) level_q[lvl][h].rem--;
				if (lvl > 0 && level_q[lvl][h].quantum > 0) level_q[lvl][h].quantum--;
				j = level_q[lvl][h];
				r.tag = j.tag;
				r.rem = j.rem;
				if (j.rem == 0 || expired) begin
					r.ev = (j.rem == 0) ? EV_FINISH : EV_KILL;
					// Return resources, saturating at 15
					if (lvl > 0)
						for (int k = 0; k < KINDS; k++)
							free_now[k] = (free_now[k] + j.need[k] > 15) ? 4'd15 :
								free_now[k] + j.need[k];
					pop_job(lvl);
				end else if (lvl > 0 && higher) begin
					r.ev = EV_PREEMPT;
				end else if (lvl > 0 && j.quantum == 0) begin
					to = (lvl < 3) ? lvl + 1 : 3;
					r.ev = EV_MOVED;
					if (to == lvl || q_count[to] < QUEUE_DEPTH) begin
						j.lvl = to;
						j.quantum = quant_cfg[to];
						pop_job(lvl);
						void'(push_job(to, j));
					end else
						level_q[lvl][h].quantum = quant_cfg[lvl];
				end else
					r.ev = EV_RAN;
			end
			run_lvl = top_level();
		end
		if (run_lvl < NLEVELS && q_count[run_lvl] > 0) begin
			r.nv = 1;
			r.nt = level_q[run_lvl][q_head[run_lvl]].tag;
		end
		return r;
	endfunction

	// Track configuration, check results, and predict accepted items
	always @(posedge clk or negedge arst_n) begin
		sched_result_t want, got;
		if (!arst_n) begin
			for (int l = 0; l < 5; l++) q_count[l] = 0;
			for (int l = 0; l < NLEVELS; l++) q_head[l] = 0;
			for (int k = 0; k < KINDS; k++)
				free_now[k] = FREE_RESET[k];
			kill_len = KILL_RESET;
			kill_left = KILL_RESET;
			quant_cfg[1] = QHIGH_RESET;
			quant_cfg[2] = QMID_RESET;
			quant_cfg[3] = QLOW_RESET;
			run_lvl = NLEVELS;
			results_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PRINTERS, CFG_SCANNERS, CFG_MODEMS, CFG_DRIVES:
						free_now[cfg_idx] = cfg_data[3:0];
					CFG_KILL: begin
						kill_len = cfg_data;
						kill_left = cfg_data;
					end
					CFG_QHIGH: quant_cfg[1] = cfg_data[3:0];
					CFG_QMID:  quant_cfg[2] = cfg_data[3:0];
					CFG_QLOW:  quant_cfg[3] = cfg_data[3:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = '{ev: m_tuser, tag: m_tdata[7:0], rem: m_tdata[15:8],
					nv: m_tdata[16], nt: m_tdata[24:17], adm: m_tdata[29:25]};
				if (results_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result ev=%0d tag=%0d", $realtime,
							got.ev, got.tag);
				end else begin
					want = results_due.pop_front();
					if (got.ev !== want.ev || got.tag !== want.tag || got.rem !== want.rem ||
							got.nv !== want.nv || got.nt !== want.nt ||
							got.adm !== want.adm) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: mismatch exp ev=%0d tag=%0d rem=%0d nv=%0d",
								" nt=%0d adm=%0d got ev=%0d tag=%0d rem=%0d nv=%0d",
								" nt=%0d adm=%0d"},
								$realtime, want.ev, want.tag, want.rem, want.nv,
								want.nt, want.adm, got.ev, got.tag, got.rem, got.nv,
								got.nt, got.adm);
					end
				end
			end
			if (s_tvalid && s_tready)
				results_due.push_back(schedule_item(s_tuser, s_tdata[33:0]));
		end
	end
endmodule

// File: dv/feedback_queue_scheduler_tb.sv
// Testbench top: clock, reset, stimulus, receiver stalls and verdict for the scheduler
`timescale 1ns / 1ps
module feedback_queue_scheduler_tb;
	import fqs_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tuser = 0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we = 0;
	logic [2:0]  cfg_idx = '0;
	logic [7:0]  cfg_data = '0;
	int          fail_count, outstanding;
	int          burst_left = 0;
	longint      cyc = 0;
	int          hold_left = 0;
	bit          held = 0;

	feedback_queue_scheduler uut (.*);
	feedback_queue_scheduler_checker chk (.*);

	always #10 clk = ~clk;

	// Receiver: one long hold-off once the sender is busy, otherwise a stall pattern
	// that steps through four settings in turn
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (hold_left > 0) begin
			m_tready <= 0;
			hold_left <= hold_left - 1;
		end else if (!held && cyc >= 8000 && s_tvalid) begin
			held <= 1;
			hold_left <= 400;
			m_tready <= 0;
		end else
			case ((cyc / 512) % 4)
				0: m_tready <= 1;
				1: m_tready <= $urandom_range(0, 1);
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (cyc % 7) < 4;
			endcase
	end

	// Offer one item and hold it until taken; idle between bursts
	task automatic offer(input logic md, input logic [33:0] fields);
		s_tuser <= md;
		s_tdata <= {6'd0, fields};
		s_tvalid <= 1;
		do @(posedge clk); while (!s_tready);
		if (burst_left == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end else
			burst_left--;
	endtask

	function automatic logic [33:0] job_fields(logic [7:0] tag, logic [1:0] lvl,
			logic [7:0] cpu, logic [15:0] needs);
		return {needs, cpu, lvl, tag};
	endfunction

	// Random arrival: mostly short jobs with modest resource needs
	function automatic logic [33:0] random_job();
		logic [15:0] needs;
		logic [7:0] cpu;
		cpu = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(1, 255);
		for (int k = 0; k < 4; k++)
			needs[4*k +: 4] = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) :
				$urandom_range(0, 15);
		return job_fields($urandom_range(0, 255),
			($urandom_range(0, 5) == 0) ? 2'd0 : 2'($urandom_range(1, 3)), cpu, needs);
	endfunction

	// Write every register while the block is idle
	task automatic set_regs(input logic [3:0] pr, sc, mo, dr, input logic [7:0] kp,
			input logic [3:0] qh, qm, ql);
		logic [7:0] vals [8];
		vals = '{pr, sc, mo, dr, kp, qh, qm, ql};
		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1;
			cfg_idx <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 0;
	endtask

	task automatic run_random(input int count, input int tick_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < tick_pct)
				offer(1, 34'($urandom()) ^ {2'($urandom()), 32'd0});
			else
				offer(0, random_job());
		end
		s_tvalid <= 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Defaults, then field extremes with directed arrivals and ticks
		set_regs(4'd2, 4'd1, 4'd1, 4'd2, 8'd20, 4'd3, 4'd2, 4'd1);
		offer(0, job_fields(8'd0, 2'd0, 8'd1, 16'h0000));
		offer(0, job_fields(8'd255, 2'd1, 8'd255, 16'h0000));
		offer(0, job_fields(8'h5A, 2'd3, 8'd2, 16'hFFFF));
		offer(0, job_fields(8'hA5, 2'd2, 8'd3, 16'h1111));
		offer(0, job_fields(8'h33, 2'd1, 8'd4, 16'h2012));
		for (int i = 0; i < 8; i++) offer(1, 34'h3_FFFF_FFFF);
		offer(0, job_fields(8'h77, 2'd3, 8'd5, 16'h0000));
		offer(0, job_fields(8'h88, 2'd0, 8'd2, 16'hFFFF));
		for (int i = 0; i < 8; i++) offer(1, 34'h0);
		s_tvalid <= 0;
		run_random(450, 45);

		// Largest settings
		set_regs(4'd15, 4'd15, 4'd15, 4'd15, 8'd255, 4'd15, 4'd15, 4'd15);
		run_random(450, 40);

		// Smallest settings: nothing fits but jobs needing nothing
		set_regs(4'd0, 4'd0, 4'd0, 4'd0, 8'd1, 4'd1, 4'd1, 4'd1);
		run_random(200, 40);

		// Random settings
		set_regs($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 15), $urandom_range(1, 255), $urandom_range(1, 15),
			$urandom_range(1, 15), $urandom_range(1, 15));
		run_random(550, 50);

		wait (outstanding == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Give up on a hung run
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
